// ===== rtl/ipcr_pkg.sv =====
package ipcr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_WAIT_HIGH = 3'd2,
        PH_CAPTURE   = 3'd3,
        PH_OK        = 3'd4,
        PH_FAILED    = 3'd5,
        PH_REPLAY    = 3'd6,
        PH_DONE      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_REPLAY = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT      = 2'd0,
        REG_MIN_ENTRIES  = 2'd1,
        REG_CARRIER_HALF = 2'd2
    } cfg_reg_t;

    localparam int DUR_W      = 16;
    localparam int MIN_W      = 9;
    localparam int HALF_W     = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUR_W-1:0]  TIMEOUT_RESET      = 16'd50000;
    localparam logic [MIN_W-1:0]  MIN_ENTRIES_RESET  = 9'd18;
    localparam logic [HALF_W-1:0] CARRIER_HALF_RESET = 8'd13;

endpackage

// ===== rtl/ir_pulse_capture_replay.sv =====
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   opcode, pin_level, entry_index, out_port
// m_        out        m_valid/m_ready   status, entry_count, read_data, ir_drive, drive_port
// cfg_      in         cfg_we            cfg_index, cfg_wdata
//
// One word can be accepted every cycle while the result side does not stall; its result
// passes through the update stage into the output register. The duration memory is read
// at the accepting edge, and state is updated and the output loaded as the word leaves the update stage.
// A synchronous active-low reset clears all control state and holds s_ready low; the
// memory is not cleared.
// A stall on the result side holds the word in the update stage and pauses input.
module ir_pulse_capture_replay
    import ipcr_pkg::*;
#(
    parameter int BUF_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic                  s_pin_level,
    input  logic [7:0]            s_entry_index,
    input  logic [3:0]            s_out_port,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [8:0]            m_entry_count,
    output logic [15:0]           m_read_data,
    output logic                  m_ir_drive,
    output logic [3:0]            m_drive_port,

    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

    logic [DUR_W-1:0]  timeout_reg;
    logic [MIN_W-1:0]  min_entries_reg;
    logic [HALF_W-1:0] carrier_half_reg;

    logic [DUR_W-1:0]  tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]  write_index_reg, write_index_next;
    logic [CNT_W-1:0]  stored_count_reg, stored_count_next;
    phase_t            phase_reg, phase_next;
    logic              timed_out_reg, timed_out_next;
    logic [HALF_W-1:0] carrier_count_reg, carrier_count_next;
    logic              carrier_level_reg, carrier_level_next;
    logic [3:0]        latched_port_reg, latched_port_next;
    logic              zero_seen_reg, zero_seen_next;

    logic              p_valid_reg;
    opcode_t           p_opcode_reg;
    logic              p_pin_reg;
    logic [7:0]        p_idx_reg;
    logic [3:0]        p_port_reg;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [8:0]        m_entry_count_reg;
    logic [DUR_W-1:0]  m_read_data_reg;
    logic              m_ir_drive_reg;
    logic [3:0]        m_drive_port_reg;

    logic              byp_valid_reg, byp_valid_next;
    logic [DUR_W-1:0]  byp_data_reg;

    logic              s_fire, p_fire;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DUR_W-1:0]  mem_wdata, mem_rdata;

    logic [DUR_W-1:0]  dur;
    logic [DUR_W-1:0]  cap_value;
    logic [DUR_W-1:0]  tick_inc;
    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] cc_inc;
    logic              to_hit;
    logic              do_finish;
    logic              do_arm;
    logic [DUR_W-1:0]  rdata;

    assign p_fire  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = aresetn && (!p_valid_reg || p_fire);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg      <= TIMEOUT_RESET;
            min_entries_reg  <= MIN_ENTRIES_RESET;
            carrier_half_reg <= CARRIER_HALF_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_TIMEOUT:      timeout_reg      <= cfg_wdata;
                REG_MIN_ENTRIES:  min_entries_reg  <= cfg_wdata[MIN_W-1:0];
                REG_CARRIER_HALF: carrier_half_reg <= cfg_wdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign dur       = byp_valid_reg ? byp_data_reg : mem_rdata;
    assign cap_value = timed_out_reg ? timeout_reg : tick_count_reg;
    assign tick_inc  = tick_count_reg + 16'd1;
    assign half      = (carrier_half_reg == '0) ? 8'd1 : carrier_half_reg;
    assign cc_inc    = carrier_count_reg + 8'd1;
    assign to_hit    = tick_count_reg >= timeout_reg;
    assign mem_waddr = AW'(write_index_reg);
    assign mem_wdata = cap_value;

    always_comb begin
        tick_count_next    = tick_count_reg;
        write_index_next   = write_index_reg;
        stored_count_next  = stored_count_reg;
        phase_next         = phase_reg;
        timed_out_next     = timed_out_reg;
        carrier_count_next = carrier_count_reg;
        carrier_level_next = carrier_level_reg;
        latched_port_next  = latched_port_reg;
        zero_seen_next     = zero_seen_reg;
        mem_we             = 1'b0;
        do_finish          = 1'b0;
        do_arm             = 1'b0;
        rdata              = '0;

        if (p_fire) begin
            case (p_opcode_reg)
                OP_TICK: begin
                    case (phase_reg)
                        PH_WAIT_LOW, PH_WAIT_HIGH: begin
                            if (p_pin_reg == (phase_reg == PH_WAIT_HIGH)) begin
                                if (to_hit) begin
                                    if (timed_out_reg) begin
                                        phase_next = PH_FAILED;
                                    end else begin
                                        timed_out_next  = 1'b1;
                                        tick_count_next = '0;
                                    end
                                end else begin
                                    tick_count_next = tick_inc;
                                end
                            end else if (phase_reg == PH_WAIT_LOW) begin
                                phase_next = PH_WAIT_HIGH;
                            end else begin
                                phase_next      = PH_CAPTURE;
                                tick_count_next = 16'd1;
                                timed_out_next  = 1'b0;
                            end
                        end
                        PH_CAPTURE: begin
                            if (p_pin_reg == write_index_reg[0]) begin
                                if (to_hit) begin
                                    if (timed_out_reg) begin
                                        do_finish = 1'b1;
                                    end else begin
                                        timed_out_next  = 1'b1;
                                        tick_count_next = '0;
                                    end
                                end else begin
                                    tick_count_next = tick_inc;
                                end
                            end else begin
                                mem_we = 1'b1;
                                if (cap_value == '0) begin
                                    zero_seen_next = 1'b1;
                                end else if (!zero_seen_reg) begin
                                    stored_count_next = stored_count_reg + 1'b1;
                                end
                                write_index_next = write_index_reg + 1'b1;
                                tick_count_next  = 16'd1;
                                timed_out_next   = 1'b0;
                                if (write_index_next >= DEPTH_CNT) begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                        PH_REPLAY: begin
                            if (write_index_reg >= stored_count_reg) begin
                                phase_next = PH_DONE;
                            end else if (tick_inc >= dur) begin
                                write_index_next   = write_index_reg + 1'b1;
                                tick_count_next    = '0;
                                carrier_count_next = '0;
                                carrier_level_next = 1'b0;
                                if (write_index_next >= stored_count_reg) begin
                                    phase_next = PH_DONE;
                                end
                            end else begin
                                tick_count_next = tick_inc;
                                if (!write_index_reg[0]) begin
                                    if (cc_inc >= half) begin
                                        carrier_count_next = '0;
                                        carrier_level_next = !carrier_level_reg;
                                    end else begin
                                        carrier_count_next = cc_inc;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                OP_ARM: begin
                    do_arm = 1'b1;
                end
                OP_REPLAY: begin
                    if (!(phase_reg inside {PH_WAIT_LOW, PH_WAIT_HIGH, PH_CAPTURE})) begin
                        latched_port_next  = p_port_reg;
                        write_index_next   = '0;
                        tick_count_next    = '0;
                        carrier_count_next = '0;
                        carrier_level_next = 1'b0;
                        phase_next = (stored_count_reg == '0) ? PH_DONE : PH_REPLAY;
                    end
                end
                default: begin
                    if (CMP_W'(p_idx_reg) < CMP_W'(stored_count_reg)) begin
                        rdata = dur;
                    end
                end
            endcase

            if (do_finish) begin
                if (CMP_W'(write_index_next) < CMP_W'(min_entries_reg)) begin
                    do_arm = 1'b1;
                end else begin
                    phase_next = PH_OK;
                end
            end

            if (do_arm) begin
                phase_next        = PH_WAIT_LOW;
                tick_count_next   = '0;
                timed_out_next    = 1'b0;
                write_index_next  = '0;
                stored_count_next = '0;
                zero_seen_next    = 1'b0;
            end
        end
    end

    // The read address follows the state as it will be once the word in the
    // update stage retires, so the next word sees its own entry.
    assign mem_raddr = (opcode_t'(s_opcode) == OP_READ) ? AW'(s_entry_index)
                                                         : AW'(write_index_next);
    assign byp_valid_next = mem_we && (mem_waddr == mem_raddr);

    ipcr_dur_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_dur_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (s_fire),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            write_index_reg   <= '0;
            stored_count_reg  <= '0;
            phase_reg         <= PH_IDLE;
            timed_out_reg     <= 1'b0;
            carrier_count_reg <= '0;
            carrier_level_reg <= 1'b0;
            latched_port_reg  <= '0;
            zero_seen_reg     <= 1'b0;
            p_valid_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            byp_valid_reg     <= 1'b0;
        end else begin
            tick_count_reg    <= tick_count_next;
            write_index_reg   <= write_index_next;
            stored_count_reg  <= stored_count_next;
            phase_reg         <= phase_next;
            timed_out_reg     <= timed_out_next;
            carrier_count_reg <= carrier_count_next;
            carrier_level_reg <= carrier_level_next;
            latched_port_reg  <= latched_port_next;
            zero_seen_reg     <= zero_seen_next;
            if (s_fire) begin
                p_valid_reg   <= 1'b1;
                byp_valid_reg <= byp_valid_next;
            end else if (p_fire) begin
                p_valid_reg <= 1'b0;
            end
            if (p_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_opcode_reg <= opcode_t'(s_opcode);
            p_pin_reg    <= s_pin_level;
            p_idx_reg    <= s_entry_index;
            p_port_reg   <= s_out_port;
            byp_data_reg <= mem_wdata;
        end
        if (p_fire) begin
            m_status_reg      <= phase_next;
            m_entry_count_reg <= 9'(stored_count_next);
            m_read_data_reg   <= rdata;
            m_ir_drive_reg    <= (phase_next == PH_REPLAY) ? carrier_level_next : 1'b0;
            m_drive_port_reg  <= latched_port_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_ir_drive    = m_ir_drive_reg;
    assign m_drive_port  = m_drive_port_reg;

endmodule

// ===== rtl/ipcr_dur_ram.sv =====
module ipcr_dur_ram
    import ipcr_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [DUR_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [DUR_W-1:0] rd_data
);

    logic [DUR_W-1:0] mem [DEPTH];
    logic [DUR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
